// ----- sv/gap_tolerant_depth_thickness_unit_defines.svh -----
`ifndef GAP_TOLERANT_DEPTH_THICKNESS_UNIT_DEFINES_SVH
`define GAP_TOLERANT_DEPTH_THICKNESS_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define GTDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gtdt check failed");

// Next-cycle implication, off during reset.
`define GTDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gtdt check failed");

`endif

// ----- sv/gtdt_pkg.sv -----
package gtdt_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned ColW    = 12;
  localparam int unsigned CountW  = 10;
  localparam int unsigned GapW    = 10;
  localparam int unsigned StepW   = 7;
  localparam int unsigned ThickW  = 8;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CountW-1:0] COUNT_CAP = 10'd1023;
  localparam logic [ThickW-1:0] THICK_CAP = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD    = 3'd0,
    CFG_MAX_GAP      = 3'd1,
    CFG_STEP         = 3'd2,
    CFG_REGION_ONLY  = 3'd3,
    CFG_INLET_RIGHT  = 3'd4,
    CFG_SPLIT_COLUMN = 3'd5
  } cfg_index_t;

  localparam logic [SampleW-1:0] THRESHOLD_RST = 8'd50;
  localparam logic [GapW-1:0]    MAX_GAP_RST   = 10'd100;
  localparam logic [StepW-1:0]   STEP_RST      = 7'd1;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [ColW-1:0]    column_x;
    logic               first_slice;
    logic               last_slice;
    logic               frame_start;
  } item_t;

  typedef struct packed {
    logic [ThickW-1:0] thickness;
    logic [ThickW-1:0] running_max;
  } result_t;

  typedef struct packed {
    logic [SampleW-1:0] threshold;
    logic [GapW-1:0]    max_gap;
    logic [StepW-1:0]   step_per_slice;
    logic               region_only;
    logic               inlet_right;
    logic [ColW-1:0]    split_column;
  } cfg_t;

  // Per-item control from the input stage to the state holders.
  typedef struct packed {
    logic advance;
    logic first_slice;
    logic last_slice;
    logic frame_start;
  } ctl_t;

endpackage

// ----- sv/gap_tolerant_depth_thickness_unit.sv -----
// Gap-tolerant depth thickness: takes one slice sample of a pixel column per
// item, one item per clock. Each item is registered, then updates the column
// counters and frame maximum; the last slice of a column yields one result
// (thickness and running frame maximum) on the result port, through the
// input register and an output register. Items that carry no result keep
// flowing while a result waits to be taken; a last slice waits only while
// the output register is full and stalled. Configuration writes take effect
// at once and belong to idle periods.
`include "gap_tolerant_depth_thickness_unit_defines.svh"

module gap_tolerant_depth_thickness_unit
  import gtdt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  item_t               item,
  output logic                result_valid,
  input  logic                result_stall,
  output result_t             result,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  cfg_t    cfg;
  item_t   stage;
  logic    stage_valid;
  logic    advance;
  ctl_t    ctl;
  logic [CountW-1:0] confirmed_now;
  logic [ThickW-1:0] thickness;
  logic [ThickW-1:0] running_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold      <= THRESHOLD_RST;
      cfg.max_gap        <= MAX_GAP_RST;
      cfg.step_per_slice <= STEP_RST;
      cfg.region_only    <= 1'b0;
      cfg.inlet_right    <= 1'b0;
      cfg.split_column   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:    cfg.threshold      <= cfg_data[SampleW-1:0];
        CFG_MAX_GAP:      cfg.max_gap        <= cfg_data[GapW-1:0];
        CFG_STEP:         cfg.step_per_slice <= cfg_data[StepW-1:0];
        CFG_REGION_ONLY:  cfg.region_only    <= cfg_data[0];
        CFG_INLET_RIGHT:  cfg.inlet_right    <= cfg_data[0];
        CFG_SPLIT_COLUMN: cfg.split_column   <= cfg_data[ColW-1:0];
        default: ;
      endcase
    end
  end

  // A last slice needs room in the output register; others always move.
  assign advance    = stage_valid && (!stage.last_slice || !result_valid || !result_stall);
  assign item_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      stage <= item;
    end
  end

  always_comb begin
    ctl.advance     = advance;
    ctl.first_slice = stage.first_slice;
    ctl.last_slice  = stage.last_slice;
    ctl.frame_start = stage.frame_start;
  end

  gtdt_column u_column (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .ctl           (ctl),
    .sample        (stage.sample),
    .confirmed_now (confirmed_now)
  );

  gtdt_frame_max u_frame_max (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .ctl           (ctl),
    .column_x      (stage.column_x),
    .confirmed_now (confirmed_now),
    .thickness     (thickness),
    .running_max   (running_max)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && stage.last_slice) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.last_slice) begin
      result.thickness   <= thickness;
      result.running_max <= running_max;
    end
  end

  `GTDT_ASSERT_NOW(a_stall_needs_item, item_stall, stage_valid && stage.last_slice)
  `GTDT_ASSERT_NEXT(a_last_gives_result, advance && stage.last_slice, result_valid)
  `GTDT_ASSERT_NOW(a_max_covers_thickness, result_valid && !cfg.region_only,
                   result.thickness <= result.running_max)

endmodule

// ----- sv/gtdt_column.sv -----
module gtdt_column
  import gtdt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  ctl_t               ctl,
  input  logic [SampleW-1:0] sample,
  output logic [CountW-1:0]  confirmed_now
);

  logic [GapW-1:0]   gap_count;
  logic [CountW-1:0] confirmed_count;
  logic              seen_hit;

  logic [GapW-1:0]   gap_base;
  logic [CountW-1:0] conf_base;
  logic              seen_base;
  logic              hit;
  logic [GapW-1:0]   bridged;
  logic [CountW+1:0] sum;
  logic [GapW-1:0]   gap_next;
  logic [CountW-1:0] confirmed_next;
  logic              seen_hit_next;

  always_comb begin
    gap_base  = ctl.first_slice ? '0 : gap_count;
    conf_base = ctl.first_slice ? '0 : confirmed_count;
    seen_base = ctl.first_slice ? 1'b0 : seen_hit;
    hit       = sample > cfg.threshold;
    bridged   = (gap_base > cfg.max_gap) ? '0 : gap_base;
    sum       = {2'b00, conf_base} + {2'b00, bridged} + {{(CountW+1){1'b0}}, 1'b1};

    gap_next      = gap_base;
    confirmed_now = conf_base;
    seen_hit_next = seen_base;
    if (hit) begin
      confirmed_now = (sum > {2'b00, COUNT_CAP}) ? COUNT_CAP : sum[CountW-1:0];
      gap_next      = '0;
      seen_hit_next = 1'b1;
    end else if (seen_base && gap_base < COUNT_CAP) begin
      gap_next = gap_base + GapW'(1);
    end
    confirmed_next = confirmed_now;

    // Column ends here: start the next one fresh.
    if (ctl.last_slice) begin
      gap_next       = '0;
      confirmed_next = '0;
      seen_hit_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_count       <= '0;
      confirmed_count <= '0;
      seen_hit        <= 1'b0;
    end else if (ctl.advance) begin
      gap_count       <= gap_next;
      confirmed_count <= confirmed_next;
      seen_hit        <= seen_hit_next;
    end
  end

endmodule

// ----- sv/gtdt_frame_max.sv -----
module gtdt_frame_max
  import gtdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  ctl_t              ctl,
  input  logic [ColW-1:0]   column_x,
  input  logic [CountW-1:0] confirmed_now,
  output logic [ThickW-1:0] thickness,
  output logic [ThickW-1:0] running_max
);

  logic [ThickW-1:0]       frame_max;
  logic [ThickW-1:0]       max_base;
  logic [CountW+StepW-1:0] prod;
  logic                    tracked;

  always_comb begin
    prod      = {{StepW{1'b0}}, confirmed_now} * {{CountW{1'b0}}, cfg.step_per_slice};
    thickness = (prod > {{(CountW+StepW-ThickW){1'b0}}, THICK_CAP}) ?
                THICK_CAP : prod[ThickW-1:0];
    if (!cfg.region_only) begin
      tracked = 1'b1;
    end else if (cfg.inlet_right) begin
      tracked = column_x < cfg.split_column;
    end else begin
      tracked = column_x > cfg.split_column;
    end
    max_base    = ctl.frame_start ? '0 : frame_max;
    running_max = (tracked && thickness > max_base) ? thickness : max_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_max <= '0;
    end else if (ctl.advance) begin
      frame_max <= ctl.last_slice ? running_max : max_base;
    end
  end

endmodule
